>>> rtl/crfifo_pkg.sv
// ----------------------------------------------------------------------------
// crfifo_pkg
// Codes and fixed widths shared by the closable ring FIFO.
// ----------------------------------------------------------------------------
package crfifo_pkg;

    // action field
    localparam int unsigned ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_SEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RECV  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd2;

    // status field
    localparam int unsigned STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // capacity register
    localparam int unsigned CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // APB register map
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_CAPACITY = 1'b0;   // word index, paddr[2]

endpackage

>>> rtl/closable_ring_fifo.sv
// ----------------------------------------------------------------------------
// closable_ring_fifo
// Bounded ring-buffer FIFO with a close flag and would-block status codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one item per handshake, carrying an action (send,
//   receive, close) and a write word used only by a send.
//   Result channel (m_*): exactly one item per input item, in order: status,
//   read word (zero unless a receive succeeded) and fill level after the
//   action.
//   APB port: register 0 (byte address 0) is capacity, the number of ring
//   entries in use; zero acts as 1, values above DEPTH act as DEPTH. Write it
//   only while the block is idle.
// Timing:
//   An item is decided in its accept cycle against the indices, count and
//   closed flag; the storage read issued at that edge lands in a register,
//   and m_valid rises once the output register is free. One item per cycle
//   is sustained while m_ready is high; a receive right after a send of the
//   same entry sees the new word, since the write lands first.
// Reset (aresetn low, synchronous): queue empty and open, capacity 16,
//   no items in flight. Storage contents are not cleared.
// Stall: while m_ready is low the output holds; one more item can be taken
//   into the decision stage, after which s_ready drops.
// ----------------------------------------------------------------------------
module closable_ring_fifo #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // input channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [crfifo_pkg::ACTION_W-1:0]         s_action,
    input  logic [DATA_WIDTH-1:0]                   s_write_data,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [crfifo_pkg::STATUS_W-1:0]         m_status,
    output logic [DATA_WIDTH-1:0]                   m_read_data,
    output logic [$clog2(DEPTH+1)-1:0]              m_fill_level,
    // configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [crfifo_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [crfifo_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [crfifo_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                    pready
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > crfifo_pkg::CAP_W) ? CNT_W : crfifo_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [crfifo_pkg::CAP_W-1:0] cap_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == crfifo_pkg::REG_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= crfifo_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            cap_reg <= pwdata[crfifo_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == crfifo_pkg::REG_CAPACITY) begin
            prdata[crfifo_pkg::CAP_W-1:0] = cap_reg;
        end
    end

    // effective capacity: clamp to 1..DEPTH
    logic [CMP_W-1:0] cap_raw;
    logic [CMP_W-1:0] cap_eff;

    assign cap_raw = CMP_W'(cap_reg);

    always_comb begin
        cap_eff = cap_raw;
        if (cap_raw == '0) begin
            cap_eff = ONE_C;
        end else if (cap_raw > DEPTH_C) begin
            cap_eff = DEPTH_C;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;

    // decision stage
    logic                          p_valid_reg;
    logic [crfifo_pkg::STATUS_W-1:0] p_status_reg, p_status_next;
    logic                          p_hit_reg, p_hit_next;   // successful receive
    logic [CNT_W-1:0]              p_fill_reg;

    // output register
    logic                            m_valid_reg;
    logic [crfifo_pkg::STATUS_W-1:0] m_status_reg;
    logic [DATA_WIDTH-1:0]           m_data_reg;
    logic [CNT_W-1:0]                m_fill_reg;

    logic s_fire;
    logic p_move;
    logic mem_we;
    logic [DATA_WIDTH-1:0] mem_rd_reg;

    assign p_move  = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p_valid_reg || p_move;
    assign s_fire  = s_valid && s_ready;

    // wrap an index at the effective capacity
    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [CMP_W-1:0] cap);
        logic [CMP_W-1:0] n;
        n = CMP_W'(idx) + ONE_C;
        if (n >= cap) begin
            step_idx = '0;
        end else begin
            step_idx = n[IDX_W-1:0];
        end
    endfunction

    always_comb begin
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        count_next    = count_reg;
        closed_next   = closed_reg;
        p_status_next = crfifo_pkg::ST_OK;
        p_hit_next    = 1'b0;
        mem_we        = 1'b0;
        case (s_action)
            crfifo_pkg::ACT_SEND: begin
                if (closed_reg) begin
                    p_status_next = crfifo_pkg::ST_CLOSED;
                end else if (CMP_W'(count_reg) >= cap_eff) begin
                    p_status_next = crfifo_pkg::ST_FULL;
                end else begin
                    mem_we      = 1'b1;
                    wr_idx_next = step_idx(wr_idx_reg, cap_eff);
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            crfifo_pkg::ACT_RECV: begin
                if (count_reg == '0) begin
                    p_status_next = closed_reg ? crfifo_pkg::ST_CLOSED
                                               : crfifo_pkg::ST_EMPTY;
                end else begin
                    p_hit_next  = 1'b1;
                    rd_idx_next = step_idx(rd_idx_reg, cap_eff);
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            crfifo_pkg::ACT_CLOSE: begin
                closed_next = 1'b1;
            end
            default: begin
                // unused code: no effect
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Ring storage: one write and one registered read per cycle
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (s_fire && mem_we) begin
            ring_mem[wr_idx_reg] <= s_write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mem_rd_reg <= ring_mem[rd_idx_reg];
        end
    end

    // ------------------------------------------------------------------
    // Control and pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            count_reg   <= '0;
            closed_reg  <= 1'b0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                rd_idx_reg <= rd_idx_next;
                wr_idx_reg <= wr_idx_next;
                count_reg  <= count_next;
                closed_reg <= closed_next;
            end
            if (s_fire) begin
                p_valid_reg <= 1'b1;
            end else if (p_move) begin
                p_valid_reg <= 1'b0;
            end
            if (p_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p_status_reg <= p_status_next;
            p_hit_reg    <= p_hit_next;
            p_fill_reg   <= count_next;
        end
        if (p_move) begin
            m_status_reg <= p_status_reg;
            m_data_reg   <= p_hit_reg ? mem_rd_reg : '0;
            m_fill_reg   <= p_fill_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_data  = m_data_reg;
    assign m_fill_level = m_fill_reg;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the closable ring FIFO. A directed table opens the
// run, random phases at a range of capacities follow, and a short directed
// close sequence with a random tail ends it. Every item is predicted by a
// shadow copy of the queue and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned FILL_W       = $clog2(DEPTH + 1);
    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned IDLE_PCT     = 7;
    localparam int unsigned END_CYCLES   = 8;
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    // action code 3 has no meaning; the block must ignore it
    localparam logic [crfifo_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [crfifo_pkg::APB_ADDR_W-1:0] CAP_ADDR =
        {crfifo_pkg::REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic [crfifo_pkg::STATUS_W-1:0] status;
        logic [DATA_W-1:0]               read_data;
        logic [FILL_W-1:0]               fill;
    } fifo_result_t;

    // one row of the directed table; rows marked typed carry their answer
    typedef struct packed {
        logic [crfifo_pkg::ACTION_W-1:0] action;
        logic [DATA_W-1:0]               data;
        logic                            rand_data;
        logic [4:0]                      reps;
        logic                            typed;
        fifo_result_t                    want;
    } vec_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                              aclk         = 1'b0;
    logic                              aresetn      = 1'b0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic [crfifo_pkg::ACTION_W-1:0]   s_action     = crfifo_pkg::ACT_SEND;
    logic [DATA_W-1:0]                 s_write_data = '0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic [crfifo_pkg::STATUS_W-1:0]   m_status;
    logic [DATA_W-1:0]                 m_read_data;
    logic [FILL_W-1:0]                 m_fill_level;
    logic                              psel         = 1'b0;
    logic                              penable      = 1'b0;
    logic                              pwrite       = 1'b0;
    logic [crfifo_pkg::APB_ADDR_W-1:0] paddr        = '0;
    logic [crfifo_pkg::APB_DATA_W-1:0] pwdata       = '0;
    logic [crfifo_pkg::APB_DATA_W-1:0] prdata;
    logic                              pready;

    closable_ring_fifo #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_data  (m_read_data),
        .m_fill_level (m_fill_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shadow queue: storage, head/tail, count, close flag, capacity register
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0]            shadow_ring [DEPTH];
    int unsigned                  shadow_head   = 0;
    int unsigned                  shadow_tail   = 0;
    int unsigned                  shadow_count  = 0;
    logic                         shadow_closed = 1'b0;
    logic [crfifo_pkg::CAP_W-1:0] shadow_cap    = crfifo_pkg::CAP_RESET;

    fifo_result_t expected_results [$];
    int unsigned  error_count = 0;
    bit           steady      = 1'b0;   // high: neither side idles

    // Directed rows. The first OPEN_ROWS run right after reset; the full
    // pass of sends there writes every ring entry, so no later receive can
    // land on an entry that was never written. The close rows run last,
    // at capacity 2 with the queue drained, since close is permanent.
    localparam int OPEN_ROWS = 8;
    localparam int ROW_COUNT = 16;

    vec_t dir_rows [ROW_COUNT] = '{
        // action, data, rnd, reps, typed, {status, read_data, fill}
        '{crfifo_pkg::ACT_RECV, 32'h0, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_EMPTY, 32'h0, 5'd0}},
        '{ACT_UNUSED, 32'hFFFFFFFF, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd0}},
        '{crfifo_pkg::ACT_SEND, 32'h0, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd1}},
        '{crfifo_pkg::ACT_SEND, 32'hFFFFFFFF, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd2}},
        '{crfifo_pkg::ACT_RECV, 32'hFFFFFFFF, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd1}},
        '{crfifo_pkg::ACT_RECV, 32'h0, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_OK, 32'hFFFFFFFF, 5'd0}},
        '{crfifo_pkg::ACT_SEND, 32'h0, 1'b1, 5'd16, 1'b0,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd0}},
        '{crfifo_pkg::ACT_SEND, 32'hFFFFFFFF, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_FULL, 32'h0, 5'd16}},
        // close sequence
        '{crfifo_pkg::ACT_SEND, 32'h0, 1'b1, 5'd2, 1'b0,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd0}},
        '{crfifo_pkg::ACT_SEND, 32'hFFFFFFFF, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_FULL, 32'h0, 5'd2}},
        '{crfifo_pkg::ACT_CLOSE, 32'hFFFFFFFF, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd2}},
        // refused while closed even though full
        '{crfifo_pkg::ACT_SEND, 32'hFFFFFFFF, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_CLOSED, 32'h0, 5'd2}},
        '{crfifo_pkg::ACT_CLOSE, 32'h0, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd2}},
        // drain after close still works
        '{crfifo_pkg::ACT_RECV, 32'h0, 1'b1, 5'd2, 1'b0,
          '{crfifo_pkg::ST_OK, 32'h0, 5'd0}},
        '{crfifo_pkg::ACT_RECV, 32'h0, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_CLOSED, 32'h0, 5'd0}},
        '{crfifo_pkg::ACT_SEND, 32'h0, 1'b0, 5'd1, 1'b1,
          '{crfifo_pkg::ST_CLOSED, 32'h0, 5'd0}}
    };

    // ------------------------------------------------------------------------
    // Predictor: applies one action to the shadow queue, returns the result
    // ------------------------------------------------------------------------
    function automatic fifo_result_t apply_action(
        input logic [crfifo_pkg::ACTION_W-1:0] act,
        input logic [DATA_W-1:0]               wdata);
        fifo_result_t r;
        int unsigned  cap;
        // zero acts as one, anything past the built depth as the depth
        cap = (shadow_cap == 0) ? 1 : ((shadow_cap > DEPTH) ? DEPTH : shadow_cap);
        r.status    = crfifo_pkg::ST_OK;
        r.read_data = '0;
        case (act)
            crfifo_pkg::ACT_SEND: begin
                if (shadow_closed) begin
                    r.status = crfifo_pkg::ST_CLOSED;
                end else if (shadow_count >= cap) begin
                    r.status = crfifo_pkg::ST_FULL;
                end else begin
                    shadow_ring[shadow_tail] = wdata;
                    // an index beyond a shrunk capacity wraps on its next step
                    shadow_tail  = (shadow_tail + 1 >= cap) ? 0 : shadow_tail + 1;
                    shadow_count = shadow_count + 1;
                end
            end
            crfifo_pkg::ACT_RECV: begin
                if (shadow_count == 0) begin
                    r.status = shadow_closed ? crfifo_pkg::ST_CLOSED
                                             : crfifo_pkg::ST_EMPTY;
                end else begin
                    r.read_data  = shadow_ring[shadow_head];
                    shadow_head  = (shadow_head + 1 >= cap) ? 0 : shadow_head + 1;
                    shadow_count = shadow_count - 1;
                end
            end
            crfifo_pkg::ACT_CLOSE: begin
                shadow_closed = 1'b1;
            end
            default: begin
                // unused code: no effect
            end
        endcase
        r.fill = FILL_W'(shadow_count);
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Input side. The expectation is queued when the item is presented; the
    // result can only come after acceptance, so order is preserved.
    // ------------------------------------------------------------------------
    task automatic drive_item(input logic [crfifo_pkg::ACTION_W-1:0] act,
                              input logic [DATA_W-1:0]               wdata,
                              input logic                            typed,
                              input fifo_result_t                    want);
        fifo_result_t pred;
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_action     = act;
        s_write_data = wdata;
        pred = apply_action(act, wdata);
        expected_results.push_back(typed ? want : pred);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic walk_rows(input int first, input int last);
        vec_t row;
        for (int i = first; i <= last; i++) begin
            row = dir_rows[i];
            for (int k = 0; k < row.reps; k++)
                drive_item(row.action, row.rand_data ? DATA_W'($urandom) : row.data,
                           row.typed, row.want);
        end
    endtask

    // mix of actions; a small share of the unused code as noise
    task automatic run_random(input int count, input int send_pct, input int close_pct);
        int                              pick;
        logic [crfifo_pkg::ACTION_W-1:0] act;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 4)
                act = ACT_UNUSED;
            else if (pick < 4 + close_pct)
                act = crfifo_pkg::ACT_CLOSE;
            else if (pick < 4 + close_pct + send_pct)
                act = crfifo_pkg::ACT_SEND;
            else
                act = crfifo_pkg::ACT_RECV;
            drive_item(act, DATA_W'($urandom), 1'b0, '0);
        end
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_capacity(input logic [crfifo_pkg::APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = CAP_ADDR;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        shadow_cap = value[crfifo_pkg::CAP_W-1:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, changed at the falling edge
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge aclk);
            m_ready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // in-order check of every accepted result
    always @(posedge aclk) begin
        fifo_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_error("result with no pending item");
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status)
                    report_error($sformatf("status %0d, want %0d", m_status, want.status));
                if (m_read_data !== want.read_data)
                    report_error($sformatf("read_data %08h, want %08h",
                                           m_read_data, want.read_data));
                if (m_fill_level !== want.fill)
                    report_error($sformatf("fill_level %0d, want %0d",
                                           m_fill_level, want.fill));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // reset state, extremes of data, fill to full at capacity 16
        walk_rows(0, OPEN_ROWS - 1);

        // shrink to the minimum while 16 entries are still stored
        settle();
        write_capacity(32'd1);
        run_random(90, 50, 0);

        // zero behaves as one
        settle();
        write_capacity(32'd0);
        run_random(70, 50, 0);

        // full depth, send-heavy, no idling on either side
        settle();
        steady = 1'b1;
        write_capacity(32'd16);
        run_random(120, 65, 0);
        settle();
        steady = 1'b0;

        // all-ones value with junk above the field: clamps to the depth
        write_capacity(($urandom & ~32'h1F) | 32'd31);
        run_random(110, 35, 0);

        settle();
        write_capacity(32'd17);
        run_random(70, 55, 0);

        settle();
        write_capacity(32'd5);
        run_random(110, 55, 0);

        settle();
        write_capacity(32'd2);
        run_random(70, 50, 0);

        settle();
        write_capacity(32'($urandom_range(16, 1)));
        run_random(110, 50, 0);

        settle();
        write_capacity(32'($urandom_range(31, 0)));
        run_random(90, 45, 0);

        // empty the queue, then the close sequence at capacity 2
        while (shadow_count != 0)
            drive_item(crfifo_pkg::ACT_RECV, DATA_W'($urandom), 1'b0, '0);
        settle();
        write_capacity(32'd2);
        walk_rows(OPEN_ROWS, ROW_COUNT - 1);

        // once closed the queue stays closed; a short random tail
        run_random(40, 40, 10);

        settle();
        repeat (END_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/crfifo_pkg.sv
rtl/closable_ring_fifo.sv
verif/tb_top.sv
